FILE: hdl/sps_pkg.sv
// Shared types, field widths and codes of the sorted priority stack.
`default_nettype none

package sps_pkg;

  // Field widths of the command and result words
  localparam int PAYLOAD_W = 16;
  localparam int GRADE_W   = 10;
  localparam int COURSES_W = 6;
  localparam int PRIO_W    = 16;
  localparam int COUNT_W   = 5;
  localparam int STATUS_W  = 2;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Cell operations
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_PUSH = 2'd1;
  localparam cell_op_t OP_POP  = 2'd2;

  typedef struct packed {
    logic                 command;
    logic [PAYLOAD_W-1:0] payload;
    logic [GRADE_W-1:0]   grade_hundredths;
    logic [COURSES_W-1:0] course_count;
  } in_word_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] front_payload;
    logic [GRADE_W-1:0]   front_grade;
    logic [COURSES_W-1:0] front_courses;
    logic [PRIO_W-1:0]    front_priority;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
    logic [STATUS_W-1:0]  status;
  } out_word_t;

  // Per-cell control: operation, occupancy and the left neighbour's compare
  typedef struct packed {
    cell_op_t op;
    logic     occ;
    logic     left_gt;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/sps_in_if.sv
// Command channel of the sorted priority stack.
`default_nettype none

interface sps_in_if;
  import sps_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

FILE: hdl/sps_out_if.sv
// Result channel of the sorted priority stack.
`default_nettype none

interface sps_out_if;
  import sps_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

FILE: hdl/sps_prio.sv
// Three-stage priority unit: weighted sum, reciprocal multiply, one-step correction.
`default_nettype none

module sps_prio #(
  parameter int MAX_GRADE_POINTS = 10,
  parameter int COURSE_TOTAL     = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sps_pkg::GRADE_W-1:0]   grade,
  input  logic [sps_pkg::COURSES_W-1:0] courses,
  output logic                          done,
  output logic [sps_pkg::PRIO_W-1:0]    prio
);
  import sps_pkg::*;

  // priority = floor(num * 2^16 / DEN), num = K1*grade + K2*courses
  localparam int K1  = 3 * COURSE_TOTAL;
  localparam int K2  = 700 * MAX_GRADE_POINTS;
  localparam int DEN = 1000 * MAX_GRADE_POINTS * COURSE_TOTAL;
  localparam int NW  = $clog2(((1 << GRADE_W) - 1) * K1 + ((1 << COURSES_W) - 1) * K2 + 1);
  localparam int DW  = $clog2(DEN);
  localparam int CW  = (NW > DW) ? NW : DW;
  // Reciprocal scaled by 2^(DW+16); below 2^17 since DEN > 2^(DW-1)
  localparam int MW  = PRIO_W + 1;
  localparam logic [63:0] MVAL = (64'd1 << (DW + PRIO_W)) / 64'(DEN);

  logic              v1, v2;
  logic [NW-1:0]     num1;
  logic [DW-1:0]     num2;
  logic              sat2;
  logic [PRIO_W-1:0] qest2;

  logic [DW+MW-1:0]  prod;
  logic [MW-1:0]     qp1;
  logic [DW+MW-1:0]  back;
  logic [DW+MW-1:0]  scaled;
  logic              inc;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // Stage one: weighted sum of the two inputs
  always_ff @(posedge clk) begin
    num1 <= NW'(grade) * NW'(K1) + NW'(courses) * NW'(K2);
  end

  // Stage two: saturation test and quotient estimate
  assign prod = (DW+MW)'(DW'(num1)) * (DW+MW)'(MW'(MVAL));

  always_ff @(posedge clk) begin
    sat2  <= CW'(num1) >= CW'(DEN);
    num2  <= DW'(num1);
    qest2 <= prod[DW +: PRIO_W];
  end

  // Stage three: raise the estimate by one where it fell short
  assign qp1    = MW'(qest2) + MW'(1);
  assign back   = (DW+MW)'(qp1) * (DW+MW)'(DEN);
  assign scaled = (DW+MW)'({num2, {PRIO_W{1'b0}}});
  assign inc    = back <= scaled;

  always_ff @(posedge clk) begin
    prio <= sat2 ? {PRIO_W{1'b1}} : qest2 + PRIO_W'(inc);
  end

endmodule

`default_nettype wire

FILE: hdl/sps_cell.sv
// One cell of the sorted chain: holds an entry, compares, shifts with neighbours.
`default_nettype none

module sps_cell #(
  parameter int EW = 48
) (
  input  logic               clk,
  input  sps_pkg::cell_ctl_t ctl,
  input  logic [EW-1:0]      new_entry,
  input  logic [EW-1:0]      left_entry,
  input  logic [EW-1:0]      right_entry,
  output logic               gt,
  output logic [EW-1:0]      entry
);
  import sps_pkg::*;

  // Priority sits in the top bits of an entry
  assign gt = ctl.occ && (entry[EW-1 -: PRIO_W] > new_entry[EW-1 -: PRIO_W]);

  // Hold, take the new entry, take from the left on push, from the right on pop
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_PUSH: begin
        if (!gt) begin
          entry <= ctl.left_gt ? new_entry : left_entry;
        end
      end
      OP_POP: begin
        entry <= right_entry;
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_stack.sv
// Top level of the sorted priority stack: control, priority unit and cell chain.
`default_nettype none

//  channel | dir | word        | accepted when
//  --------+-----+-------------+-----------------------
//  req     | in  | in_word_t   | req.valid & req.ready
//  rsp     | out | out_word_t  | rsp.valid & rsp.ready
//
//  A command's result word is registered after the three priority stages (the
//  first loads at the accepting edge), the cell chain update and the output
//  register load, which waits while a stalled result is not yet taken; req.ready
//  stays low from acceptance until the result is registered, so a new command
//  is accepted only after the previous result word is registered.
//  Synchronous reset empties the stack and holds req.ready low; cells keep data.
//  A stalled result holds in the output register while the next command runs.

module sorted_priority_stack #(
  parameter int DEPTH            = 16,
  parameter int MAX_GRADE_POINTS = 10,
  parameter int COURSE_TOTAL     = 30,
  parameter int PAYLOAD_WIDTH    = 16
) (
  input  logic      clk,
  input  logic      rst,
  sps_in_if.sink    req,
  sps_out_if.source rsp
);
  import sps_pkg::*;

  localparam int SW   = (PAYLOAD_WIDTH < PAYLOAD_W) ? PAYLOAD_WIDTH : PAYLOAD_W;
  localparam int EW   = PRIO_W + SW + GRADE_W + COURSES_W;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic                busy;
  logic                pend;
  in_word_t            held;
  logic [CNTW-1:0]     count;
  logic [CNTW-1:0]     count_next;
  logic [STATUS_W-1:0] st;
  logic [STATUS_W-1:0] st_next;
  cell_op_t            op;
  logic                accept;
  logic                load;
  logic                prio_done;
  logic [PRIO_W-1:0]   prio;
  logic [EW-1:0]       new_entry;
  logic [EW-1:0]       entries [DEPTH];
  logic [DEPTH-1:0]    gt;
  logic [EW-1:0]       front;
  logic                nonempty;

  assign req.ready = !busy && !rst;
  assign accept    = req.valid && req.ready;
  assign load      = pend && (!rsp.valid || rsp.ready);

  // Capture the command word
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= req.word;
    end
  end

  sps_prio #(
    .MAX_GRADE_POINTS (MAX_GRADE_POINTS),
    .COURSE_TOTAL     (COURSE_TOTAL)
  ) u_prio (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .grade   (req.word.grade_hundredths),
    .courses (req.word.course_count),
    .done    (prio_done),
    .prio    (prio)
  );

  // Decide the chain operation, new count and status
  always_comb begin
    op         = OP_HOLD;
    count_next = count;
    st_next    = ST_OK;
    if (held.command == CMD_PUSH) begin
      if (count == CNTW'(DEPTH)) begin
        st_next = ST_FULL;
      end else begin
        op         = OP_PUSH;
        count_next = count + CNTW'(1);
      end
    end else if (count == '0) begin
      st_next = ST_EMPTY;
    end else begin
      op         = OP_POP;
      count_next = count - CNTW'(1);
    end
  end

  assign new_entry = {prio, SW'(held.payload), held.grade_hundredths, held.course_count};

  // Chain of cells, cell 0 at the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t     ctl;
    logic [EW-1:0] left_e;
    logic [EW-1:0] right_e;

    assign ctl.op  = prio_done ? op : OP_HOLD;
    assign ctl.occ = CNTW'(i) < count;

    if (i == 0) begin : g_first
      assign ctl.left_gt = 1'b1;
      assign left_e      = new_entry;
    end else begin : g_mid
      assign ctl.left_gt = gt[i-1];
      assign left_e      = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    sps_cell #(
      .EW (EW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .gt          (gt[i]),
      .entry       (entries[i])
    );
  end

  // Sequence one command through priority, update and output
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (prio_done) begin
        count <= count_next;
        pend  <= 1'b1;
      end
      if (load) begin
        pend      <= 1'b0;
        busy      <= 1'b0;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Hold the status until the result word is loaded
  always_ff @(posedge clk) begin
    if (prio_done) begin
      st <= st_next;
    end
  end

  assign front    = entries[0];
  assign nonempty = count != '0;

  // Load the result word from the front cell
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.word.front_payload  <= nonempty ? PAYLOAD_W'(front[GRADE_W+COURSES_W +: SW]) : '0;
      rsp.word.front_grade    <= nonempty ? front[COURSES_W +: GRADE_W] : '0;
      rsp.word.front_courses  <= nonempty ? front[COURSES_W-1:0] : '0;
      rsp.word.front_priority <= nonempty ? front[EW-1 -: PRIO_W] : '0;
      rsp.word.entry_count    <= COUNT_W'(count);
      rsp.word.is_empty       <= !nonempty;
      rsp.word.status         <= st;
    end
  end

endmodule

`default_nettype wire
